[src/gray_erode_3x3_stream_assert.svh]
// ----------------------------------------------------------------------------
// gray_erode_3x3_stream assertion macros
// concurrent assertion shorthands, clocked on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef GRAY_ERODE_3X3_STREAM_ASSERT_SVH
`define GRAY_ERODE_3X3_STREAM_ASSERT_SVH

// consequent checked on the same edge
`define GE3S_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked on the following edge
`define GE3S_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ge3s_pkg.sv]
// ----------------------------------------------------------------------------
// ge3s_pkg
// shared sizes, register codes, types and min helpers for the 3x3 erosion
// ----------------------------------------------------------------------------
package ge3s_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int LANES       = 4;
    localparam int PIX_W       = 8;
    localparam int DATA_W      = LANES * PIX_W;
    localparam int MAX_WORDS   = MAX_WIDTH / LANES;
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
    localparam int WORD_W      = $clog2(MAX_WORDS);

    localparam int ROWS_CFG_W  = 12;
    localparam int WORDS_CFG_W = 10;
    localparam int SHAPE_W     = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int REG_IDX_W   = 2;
    localparam int PADDR_W     = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_WORDS    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_SHAPE = 2'd2;

    localparam logic [SHAPE_W-1:0] SHAPE_CROSS   = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_ELLIPSE = 2'd2;

    localparam logic OP_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // one window column: row above, centre row, row below
    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    // per-item decode, worked out from the position counters at transfer time
    typedef struct packed {
        logic              live;       // row still inside the frame, pixels used
        logic              tail;       // row one past the frame, line buffers only
        logic              mid_mem;    // centre row comes from the middle line
        logic              above_mem;  // upper row comes from the upper line
        logic              wr_above;   // middle line moves up into the upper line
        logic              first_word; // word 0 of its row
        logic              emit;       // a result word leaves on this item
        logic              top_rep;    // result lies on the top row
        logic              bot_rep;    // result lies on the bottom row
        logic              fs;         // result is the first of the frame
        logic              fe;         // result is the last of the frame
        logic [WORD_W-1:0] addr;       // line buffer word address
    } t_item_ctl;

    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_line_wr;

    function automatic t_pix min_pix(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    // minimum over one column, centre only or all three rows
    function automatic t_pix col_min(input t_col x, input logic full,
                                     input logic top_rep, input logic bot_rep);
        t_pix t;
        t_pix b;
        t_pix m;
        t = top_rep ? x.mid : x.top;
        b = bot_rep ? x.mid : x.bot;
        m = x.mid;
        if (full) begin
            m = min_pix(m, min_pix(t, b));
        end
        return m;
    endfunction

    // one output pixel from its left, centre and right columns
    function automatic t_pix erode_lane(input t_col l, input t_col c, input t_col r,
                                        input logic rect, input logic top_rep,
                                        input logic bot_rep);
        return min_pix(col_min(c, 1'b1, top_rep, bot_rep),
                       min_pix(col_min(l, rect, top_rep, bot_rep),
                               col_min(r, rect, top_rep, bot_rep)));
    endfunction

endpackage

[src/gray_erode_3x3_stream.sv]
// ----------------------------------------------------------------------------
// gray_erode_3x3_stream
// streaming 3x3 grayscale erosion, four pixels per word, edge replication
// ----------------------------------------------------------------------------
// usage
//  - input stream: one transfer per packed word of four 8-bit pixels, raster
//    order, first pixel in the lowest byte; tuser high marks a drain tick
//  - output stream: eroded words in the same packing, tuser on the first word
//    of the frame, tlast on the last one
//  - frame size and kernel shape sit behind the apb port; write them only
//    while the block is idle, a write drops any frame in progress
//  - result word (r,w) leaves after input word (r+1,w+1) has been taken;
//    after the last pixel word send row_words+1 drain ticks to flush
//  - drain ticks sent before the frame's last pixel word are taken and dropped
//  - path: the transfer that completes a neighbourhood is held in the item
//    register, and its result is then written to the output register
//  - throughput: one word per cycle unless the receiver stalls, set by the single
//    item register feeding the four-lane minimum and the registered line memory read
//  - reset clears the position counters and both pipeline valids; the line
//    memories keep their contents and are read only where already written
//  - when the receiver stalls the result stays in the output register and
//    one more item waits in the item register before tready drops
// ----------------------------------------------------------------------------
module gray_erode_3x3_stream (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [ge3s_pkg::DATA_W-1:0]         i_s_tdata,  // in_pix0, in_pix1, in_pix2, in_pix3
    input  logic                                i_s_tuser,  // operation
    // output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [ge3s_pkg::DATA_W-1:0]         o_m_tdata,  // out_pix0, out_pix1, out_pix2, out_pix3
    output logic                                o_m_tlast,  // frame_end
    output logic                                o_m_tuser,  // frame_start
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ge3s_pkg::PADDR_W-1:0]        paddr,
    input  logic [ge3s_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ge3s_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [ge3s_pkg::ROW_W-1:0]       rows;
    logic [ge3s_pkg::WORDS_CFG_W-1:0] words;
    logic                             rect;
    logic                             cfg_clear;
    logic                             ignore;
    logic                             proc;
    ge3s_pkg::t_item_ctl              ctl;
    ge3s_pkg::t_line_wr               above_wr;
    logic [ge3s_pkg::DATA_W-1:0]      mid_rd;
    logic [ge3s_pkg::DATA_W-1:0]      above_rd;

    // writes complete in the access cycle, no wait states
    assign pready = 1'b1;

    // a transfer that is not a dropped drain tick enters the pipeline
    assign proc = i_s_tvalid && o_s_tready && !ignore;

    ge3s_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_rows  (rows),
        .o_words (words),
        .o_rect  (rect),
        .o_clear (cfg_clear)
    );

    ge3s_pos u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_clear),
        .i_rows   (rows),
        .i_words  (words),
        .i_op     (i_s_tuser),
        .i_proc   (proc),
        .o_ignore (ignore),
        .o_ctl    (ctl)
    );

    // memories are read on the transfer edge; data lines up with the item register
    ge3s_linebuf u_linebuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (proc),
        .i_addr     (ctl.addr),
        .i_wr_mid   (proc && ctl.live),
        .i_pix      (i_s_tdata),
        .i_above_wr (above_wr),
        .o_mid      (mid_rd),
        .o_above    (above_rd)
    );

    ge3s_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (proc),
        .i_pix      (i_s_tdata),
        .i_ctl      (ctl),
        .i_mid_rd   (mid_rd),
        .i_above_rd (above_rd),
        .i_rect     (rect),
        .i_m_tready (i_m_tready),
        .o_ready    (o_s_tready),
        .o_above_wr (above_wr),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

[src/ge3s_cfg.sv]
// ----------------------------------------------------------------------------
// ge3s_cfg
// register file behind the apb port, with clamped frame sizes
// ----------------------------------------------------------------------------
module ge3s_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ge3s_pkg::PADDR_W-1:0]        paddr,
    input  logic [ge3s_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ge3s_pkg::CFG_DATA_W-1:0]     prdata,
    output logic [ge3s_pkg::ROW_W-1:0]          o_rows,
    output logic [ge3s_pkg::WORDS_CFG_W-1:0]    o_words,
    output logic                                o_rect,
    output logic                                o_clear
);

    logic [ge3s_pkg::ROWS_CFG_W-1:0]  r_frame_rows;
    logic [ge3s_pkg::WORDS_CFG_W-1:0] r_row_words;
    logic [ge3s_pkg::SHAPE_W-1:0]     r_kernel_shape;
    logic [ge3s_pkg::REG_IDX_W-1:0]   idx;
    logic                             wr;

    assign idx = paddr[ge3s_pkg::PADDR_W-1:2];
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows   <= ge3s_pkg::ROWS_CFG_W'(1);
            r_row_words    <= ge3s_pkg::WORDS_CFG_W'(1);
            r_kernel_shape <= '0;
        end else if (wr) begin
            case (idx)
                ge3s_pkg::REG_FRAME_ROWS: begin
                    r_frame_rows <= pwdata[ge3s_pkg::ROWS_CFG_W-1:0];
                end
                ge3s_pkg::REG_ROW_WORDS: begin
                    r_row_words <= pwdata[ge3s_pkg::WORDS_CFG_W-1:0];
                end
                ge3s_pkg::REG_KERNEL_SHAPE: begin
                    r_kernel_shape <= pwdata[ge3s_pkg::SHAPE_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // any write to a known register drops the frame in progress
    always_comb begin
        o_clear = 1'b0;
        prdata  = '0;
        case (idx)
            ge3s_pkg::REG_FRAME_ROWS: begin
                o_clear = wr;
                prdata  = ge3s_pkg::CFG_DATA_W'(r_frame_rows);
            end
            ge3s_pkg::REG_ROW_WORDS: begin
                o_clear = wr;
                prdata  = ge3s_pkg::CFG_DATA_W'(r_row_words);
            end
            ge3s_pkg::REG_KERNEL_SHAPE: begin
                o_clear = wr;
                prdata  = ge3s_pkg::CFG_DATA_W'(r_kernel_shape);
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_frame_rows == '0) begin
            o_rows = ge3s_pkg::ROW_W'(1);
        end else if (r_frame_rows > ge3s_pkg::ROWS_CFG_W'(ge3s_pkg::MAX_HEIGHT)) begin
            o_rows = ge3s_pkg::ROW_W'(ge3s_pkg::MAX_HEIGHT);
        end else begin
            o_rows = ge3s_pkg::ROW_W'(r_frame_rows);
        end
    end

    always_comb begin
        if (r_row_words == '0) begin
            o_words = ge3s_pkg::WORDS_CFG_W'(1);
        end else if (r_row_words > ge3s_pkg::WORDS_CFG_W'(ge3s_pkg::MAX_WORDS)) begin
            o_words = ge3s_pkg::WORDS_CFG_W'(ge3s_pkg::MAX_WORDS);
        end else begin
            o_words = r_row_words;
        end
    end

    // unknown shape code behaves as the full square
    assign o_rect = !(r_kernel_shape == ge3s_pkg::SHAPE_CROSS ||
                      r_kernel_shape == ge3s_pkg::SHAPE_ELLIPSE);

endmodule

[src/ge3s_pos.sv]
// ----------------------------------------------------------------------------
// ge3s_pos
// input position counters and per-item decode
// ----------------------------------------------------------------------------
module ge3s_pos (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_clear,
    input  logic [ge3s_pkg::ROW_W-1:0]       i_rows,
    input  logic [ge3s_pkg::WORDS_CFG_W-1:0] i_words,
    input  logic                             i_op,
    input  logic                             i_proc,
    output logic                             o_ignore,
    output ge3s_pkg::t_item_ctl              o_ctl
);

    logic [ge3s_pkg::ROW_W-1:0]       r_row;
    logic [ge3s_pkg::WORD_W-1:0]      r_word;
    logic [ge3s_pkg::WORDS_CFG_W-1:0] word_inc;
    logic                             live;
    logic                             tail;
    logic                             row_nz;
    logic                             row_ge2;
    logic                             word_nz;

    assign live     = r_row < i_rows;
    assign tail     = r_row == i_rows;
    assign row_nz   = r_row != '0;
    assign row_ge2  = r_row >= ge3s_pkg::ROW_W'(2);
    assign word_nz  = r_word != '0;
    assign word_inc = ge3s_pkg::WORDS_CFG_W'(r_word) + ge3s_pkg::WORDS_CFG_W'(1);

    // a drain tick is dropped until the last input word has come in
    assign o_ignore = (i_op == ge3s_pkg::OP_DRAIN) && live;

    always_comb begin
        o_ctl            = '0;
        o_ctl.live       = live;
        o_ctl.tail       = tail;
        o_ctl.mid_mem    = row_nz;
        o_ctl.above_mem  = row_ge2;
        o_ctl.wr_above   = live && row_nz;
        o_ctl.first_word = !word_nz;
        o_ctl.emit       = (row_nz && word_nz) || (row_ge2 && !word_nz);
        o_ctl.top_rep    = word_nz ? (r_row == ge3s_pkg::ROW_W'(1))
                                   : (r_row == ge3s_pkg::ROW_W'(2));
        o_ctl.bot_rep    = word_nz ? (r_row >= i_rows) : (r_row > i_rows);
        o_ctl.fs         = word_nz ? (r_word == ge3s_pkg::WORD_W'(1) &&
                                      r_row == ge3s_pkg::ROW_W'(1))
                                   : (r_row == ge3s_pkg::ROW_W'(2) &&
                                      i_words == ge3s_pkg::WORDS_CFG_W'(1));
        o_ctl.fe         = !word_nz && !live && !tail;
        o_ctl.addr       = r_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_row  <= '0;
            r_word <= '0;
        end else if (i_proc) begin
            if (!live && !tail) begin
                // last flush item: the frame is complete
                r_row  <= '0;
                r_word <= '0;
            end else if (word_inc >= i_words) begin
                r_row  <= r_row + ge3s_pkg::ROW_W'(1);
                r_word <= '0;
            end else begin
                r_word <= word_inc[ge3s_pkg::WORD_W-1:0];
            end
        end
    end

endmodule

[src/ge3s_linebuf.sv]
// ----------------------------------------------------------------------------
// ge3s_linebuf
// two line memories, one packed word per entry, with upper-line forwarding
// ----------------------------------------------------------------------------
module ge3s_linebuf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd,
    input  logic [ge3s_pkg::WORD_W-1:0] i_addr,
    input  logic                        i_wr_mid,
    input  logic [ge3s_pkg::DATA_W-1:0] i_pix,
    input  ge3s_pkg::t_line_wr          i_above_wr,
    output logic [ge3s_pkg::DATA_W-1:0] o_mid,
    output logic [ge3s_pkg::DATA_W-1:0] o_above
);

    logic [ge3s_pkg::DATA_W-1:0] mem_mid   [ge3s_pkg::MAX_WORDS];
    logic [ge3s_pkg::DATA_W-1:0] mem_above [ge3s_pkg::MAX_WORDS];
    logic [ge3s_pkg::DATA_W-1:0] r_mid_rd;
    logic [ge3s_pkg::DATA_W-1:0] r_above_rd;
    logic [ge3s_pkg::DATA_W-1:0] r_fwd_data;
    logic                        r_fwd;

    // middle line: read old entry and write the new row in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_mid_rd <= mem_mid[i_addr];
        end
        if (i_wr_mid) begin
            mem_mid[i_addr] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_above_wr.en) begin
            mem_above[i_above_wr.addr] <= i_above_wr.data;
        end
        if (i_rd) begin
            r_above_rd <= mem_above[i_addr];
            r_fwd_data <= i_above_wr.data;
        end
    end

    // a write landing on the word being read in the same cycle wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd) begin
            r_fwd <= i_above_wr.en && (i_above_wr.addr == i_addr);
        end
    end

    assign o_mid   = r_mid_rd;
    assign o_above = r_fwd ? r_fwd_data : r_above_rd;

endmodule

[src/ge3s_window.sv]
// ----------------------------------------------------------------------------
// ge3s_window
// item register, sliding window, four-lane minimum and result register
// ----------------------------------------------------------------------------
module ge3s_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [ge3s_pkg::DATA_W-1:0] i_pix,
    input  ge3s_pkg::t_item_ctl         i_ctl,
    input  logic [ge3s_pkg::DATA_W-1:0] i_mid_rd,
    input  logic [ge3s_pkg::DATA_W-1:0] i_above_rd,
    input  logic                        i_rect,
    input  logic                        i_m_tready,
    output logic                        o_ready,
    output ge3s_pkg::t_line_wr          o_above_wr,
    output logic                        o_m_tvalid,
    output logic [ge3s_pkg::DATA_W-1:0] o_m_tdata,
    output logic                        o_m_tlast,
    output logic                        o_m_tuser
);

    logic                        r_a_valid;
    logic [ge3s_pkg::DATA_W-1:0] r_a_pix;
    ge3s_pkg::t_item_ctl         r_a_ctl;
    ge3s_pkg::t_col              r_win [ge3s_pkg::LANES+1];
    ge3s_pkg::t_col              n_win [ge3s_pkg::LANES+1];
    ge3s_pkg::t_col              nc    [ge3s_pkg::LANES];
    ge3s_pkg::t_col              cols  [ge3s_pkg::LANES+2];
    logic [ge3s_pkg::DATA_W-1:0] mids;
    logic [ge3s_pkg::DATA_W-1:0] res;
    logic                        r_out_valid;
    logic [ge3s_pkg::DATA_W-1:0] r_out_data;
    logic                        r_out_fs;
    logic                        r_out_fe;
    logic                        out_free;
    logic                        a_go;

    assign out_free = !r_out_valid || i_m_tready;
    assign a_go     = r_a_valid && (!r_a_ctl.emit || out_free);
    assign o_ready  = !r_a_valid || a_go;

    // new column triples for the four pixels of the word
    always_comb begin
        for (int k = 0; k < ge3s_pkg::LANES; k++) begin
            mids[k*ge3s_pkg::PIX_W +: ge3s_pkg::PIX_W] =
                r_a_ctl.mid_mem ? i_mid_rd[k*ge3s_pkg::PIX_W +: ge3s_pkg::PIX_W]
                                : r_a_pix[k*ge3s_pkg::PIX_W +: ge3s_pkg::PIX_W];
            nc[k].mid = mids[k*ge3s_pkg::PIX_W +: ge3s_pkg::PIX_W];
            nc[k].top = r_a_ctl.above_mem
                      ? i_above_rd[k*ge3s_pkg::PIX_W +: ge3s_pkg::PIX_W]
                      : nc[k].mid;
            nc[k].bot = r_a_ctl.live ? r_a_pix[k*ge3s_pkg::PIX_W +: ge3s_pkg::PIX_W]
                                     : nc[k].mid;
        end
    end

    // right neighbour is the next word's first column, or the edge replicated
    always_comb begin
        for (int j = 0; j <= ge3s_pkg::LANES; j++) begin
            cols[j] = r_win[j];
        end
        cols[ge3s_pkg::LANES+1] = r_a_ctl.first_word ? r_win[ge3s_pkg::LANES] : nc[0];
    end

    always_comb begin
        for (int k = 0; k < ge3s_pkg::LANES; k++) begin
            res[k*ge3s_pkg::PIX_W +: ge3s_pkg::PIX_W] =
                ge3s_pkg::erode_lane(cols[k], cols[k+1], cols[k+2], i_rect,
                                     r_a_ctl.top_rep, r_a_ctl.bot_rep);
        end
    end

    // left neighbour is kept from the previous word, or replicated at word 0
    always_comb begin
        n_win[0] = r_a_ctl.first_word ? nc[0] : r_win[ge3s_pkg::LANES];
        for (int k = 0; k < ge3s_pkg::LANES; k++) begin
            n_win[k+1] = nc[k];
        end
    end

    always_comb begin
        o_above_wr.en   = a_go && r_a_ctl.wr_above;
        o_above_wr.addr = r_a_ctl.addr;
        o_above_wr.data = mids;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_a_valid <= 1'b1;
            end else if (a_go) begin
                r_a_valid <= 1'b0;
            end
            if (a_go && r_a_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a_pix <= i_pix;
            r_a_ctl <= i_ctl;
        end
        if (a_go) begin
            r_win <= n_win;
        end
        if (a_go && r_a_ctl.emit) begin
            r_out_data <= res;
            r_out_fs   <= r_a_ctl.fs;
            r_out_fe   <= r_a_ctl.fe;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_fe;
    assign o_m_tuser  = r_out_fs;

endmodule

[src/ge3s_checker.sv]
// ----------------------------------------------------------------------------
// ge3s_checker
// port-level checks on the erosion stream, bound to the top level
// ----------------------------------------------------------------------------
`include "gray_erode_3x3_stream_assert.svh"

module ge3s_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [ge3s_pkg::DATA_W-1:0] o_m_tdata,
    input logic                        o_m_tlast,
    input logic                        o_m_tuser,
    input logic                        pready
);

    // a stalled result holds still
    `GE3S_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser), "stalled result changed")

    // a fresh result follows an input transfer that passed through the item register
    `GE3S_ASSERT_NOW(a_out_after_in, $rose(o_m_tvalid), $past(i_s_tvalid && o_s_tready, 2), "result without matching input transfer")

    // with the output register empty the input side is never held off
    `GE3S_ASSERT_NOW(a_ready_when_empty, !o_m_tvalid, o_s_tready, "input stalled with empty output")

    `GE3S_ASSERT_NOW(a_pready_high, 1'b1, pready, "config port inserted a wait state")

endmodule

bind gray_erode_3x3_stream ge3s_checker u_ge3s_checker (.*);
